// ===== sv/mqts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-stack minimum queue.
// No dependencies; the queue and the minimum unit import this package.
package mqts_pkg;

   // Queue size and derived widths
   localparam int CAPACITY = 64;
   localparam int DEPTH_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int TOTAL_W  = DEPTH_W + 1;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 7;

   // Value reported for pop and minimum on an empty queue
   localparam logic signed [DATA_W-1:0] EMPTY_SENTINEL = 32'sd2000000000;

   // Operation codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  pop_value;
      logic                      empty_flag;
      logic                      overflow_flag;
      logic signed [DATA_W-1:0]  queue_min;
      logic        [COUNT_W-1:0] count;
   } rsp_type;

   // Removal stack entry: value and the running minimum of the entries below it
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] below_min;
   } out_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_RD,
      ST_POP_WB,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_REPORT
   } state_type;

   // Operand routing of the shared minimum unit
   typedef enum logic [1:0] {
      SEL_PUSH,
      SEL_FILL,
      SEL_REPORT
   } min_sel_type;

   typedef struct packed {
      logic              in_we;
      logic [ADDR_W-1:0] in_waddr;
      logic [ADDR_W-1:0] in_raddr;
      logic              out_we;
      logic [ADDR_W-1:0] out_waddr;
      logic [ADDR_W-1:0] out_raddr;
      min_sel_type       min_sel;
   } ctrl_type;

endpackage

// ===== sv/min_queue_two_stacks.sv =====
`timescale 1ns / 1ps
// Two-stack FIFO with running minimum; one item in flight, one shared compare unit.
// Push: push state, then report. Pop from a loaded removal stack: pop read, pop writeback,
// then report. Pop on an empty removal stack first moves the whole insertion stack over,
// one entry at a time (memory read, then write). Empty pop or full push: report only.
// rsp_strobe pulses in the first cycle busy is low; the receiver cannot stall.
// Synchronous reset empties both stacks at once; memory contents are not cleared.
module min_queue_two_stacks
   import mqts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [DEPTH_W-1:0]       in_depth_ff, in_depth_in;
   logic [DEPTH_W-1:0]       out_depth_ff, out_depth_in;
   logic signed [DATA_W-1:0] in_min_ff, in_min_in;
   logic signed [DATA_W-1:0] out_min_ff, out_min_in;
   logic signed [DATA_W-1:0] pop_value_ff, pop_value_in;
   logic                     empty_ff, empty_in;
   logic                     overflow_ff, overflow_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;

   ctrl_type                 ctrl;
   logic                     accept;
   logic [TOTAL_W-1:0]       total;
   logic                     full;
   logic [DEPTH_W-1:0]       in_dec;
   logic [DEPTH_W-1:0]       out_dec;
   logic signed [DATA_W-1:0] in_rdata;
   logic [$bits(out_entry_type)-1:0] out_rdata_raw;
   out_entry_type            out_rdata;
   out_entry_type            out_wdata;
   logic signed [DATA_W-1:0] unit_a, unit_b, unit_min;
   logic signed [DATA_W-1:0] report_min;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign total   = TOTAL_W'(in_depth_ff) + TOTAL_W'(out_depth_ff);
   assign full    = (total >= TOTAL_W'(CAPACITY));
   assign in_dec  = in_depth_ff - DEPTH_W'(1);
   assign out_dec = out_depth_ff - DEPTH_W'(1);

   // Stack memories
   mqts_stack_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_in_ram (
      .clock   (clock),
      .wr_en   (ctrl.in_we),
      .wr_addr (ctrl.in_waddr),
      .wr_data (req_ff.value),
      .rd_addr (ctrl.in_raddr),
      .rd_data (in_rdata)
   );

   assign out_wdata.value     = in_rdata;
   assign out_wdata.below_min = out_min_ff;

   mqts_stack_ram #(
      .WIDTH ($bits(out_entry_type)),
      .DEPTH (CAPACITY)
   ) u_out_ram (
      .clock   (clock),
      .wr_en   (ctrl.out_we),
      .wr_addr (ctrl.out_waddr),
      .wr_data (out_wdata),
      .rd_addr (ctrl.out_raddr),
      .rd_data (out_rdata_raw)
   );

   assign out_rdata = out_entry_type'(out_rdata_raw);

   // Route operands to the shared minimum unit
   always_comb begin
      case (ctrl.min_sel)
         SEL_PUSH: begin
            unit_a = req_ff.value;
            unit_b = in_min_ff;
         end
         SEL_FILL: begin
            unit_a = in_rdata;
            unit_b = out_min_ff;
         end
         SEL_REPORT: begin
            unit_a = in_min_ff;
            unit_b = out_min_ff;
         end
         default: begin
            unit_a = in_min_ff;
            unit_b = out_min_ff;
         end
      endcase
   end

   mqts_min_unit u_min (
      .operand_a (unit_a),
      .operand_b (unit_b),
      .min_value (unit_min)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_PUSH) begin
                  state_in = full ? ST_REPORT : ST_PUSH;
               end else if (out_depth_ff != '0) begin
                  state_in = ST_POP_RD;
               end else if (in_depth_ff != '0) begin
                  state_in = ST_FILL_RD;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_PUSH:    state_in = ST_REPORT;
         ST_POP_RD:  state_in = ST_POP_WB;
         ST_POP_WB:  state_in = ST_REPORT;
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            state_in = (in_depth_ff > DEPTH_W'(1)) ? ST_FILL_RD : ST_POP_RD;
         end
         ST_REPORT:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctrl.in_we     = 1'b0;
      ctrl.in_waddr  = in_depth_ff[ADDR_W-1:0];
      ctrl.in_raddr  = in_dec[ADDR_W-1:0];
      ctrl.out_we    = 1'b0;
      ctrl.out_waddr = out_depth_ff[ADDR_W-1:0];
      ctrl.out_raddr = out_dec[ADDR_W-1:0];
      ctrl.min_sel   = SEL_REPORT;
      case (state_ff)
         ST_PUSH: begin
            ctrl.in_we   = 1'b1;
            ctrl.min_sel = SEL_PUSH;
         end
         ST_FILL_WR: begin
            ctrl.out_we  = 1'b1;
            ctrl.min_sel = SEL_FILL;
         end
         default: begin
            ctrl.min_sel = SEL_REPORT;
         end
      endcase
   end

   // Queue minimum from the two stack-top minimums, valid by depth
   always_comb begin
      if ((in_depth_ff != '0) && (out_depth_ff != '0)) begin
         report_min = unit_min;
      end else if (in_depth_ff != '0) begin
         report_min = in_min_ff;
      end else if (out_depth_ff != '0) begin
         report_min = out_min_ff;
      end else begin
         report_min = EMPTY_SENTINEL;
      end
   end

   // Datapath next values
   always_comb begin
      req_in        = req_ff;
      in_depth_in   = in_depth_ff;
      out_depth_in  = out_depth_ff;
      in_min_in     = in_min_ff;
      out_min_in    = out_min_ff;
      pop_value_in  = pop_value_ff;
      empty_in      = empty_ff;
      overflow_in   = overflow_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               pop_value_in = (req_data.func == FUNC_POP) ? EMPTY_SENTINEL : '0;
               empty_in     = (req_data.func == FUNC_POP) &&
                              (in_depth_ff == '0) && (out_depth_ff == '0);
               overflow_in  = (req_data.func == FUNC_PUSH) && full;
            end
         end
         ST_PUSH: begin
            in_min_in   = (in_depth_ff != '0) ? unit_min : req_ff.value;
            in_depth_in = in_depth_ff + DEPTH_W'(1);
         end
         ST_POP_WB: begin
            pop_value_in = out_rdata.value;
            out_min_in   = out_rdata.below_min;
            out_depth_in = out_depth_ff - DEPTH_W'(1);
         end
         ST_FILL_WR: begin
            out_min_in   = (out_depth_ff != '0) ? unit_min : in_rdata;
            out_depth_in = out_depth_ff + DEPTH_W'(1);
            in_depth_in  = in_depth_ff - DEPTH_W'(1);
         end
         ST_REPORT: begin
            rsp_in.pop_value     = pop_value_ff;
            rsp_in.empty_flag    = empty_ff;
            rsp_in.overflow_flag = overflow_ff;
            rsp_in.queue_min     = report_min;
            rsp_in.count         = COUNT_W'(total);
            rsp_strobe_in        = 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_depth_ff   <= '0;
         out_depth_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_depth_ff   <= in_depth_in;
         out_depth_ff  <= out_depth_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      in_min_ff    <= in_min_in;
      out_min_ff   <= out_min_in;
      pop_value_ff <= pop_value_in;
      empty_ff     <= empty_in;
      overflow_ff  <= overflow_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      total <= TOTAL_W'(CAPACITY))
      else $error("stack depths exceed capacity");

   a_fill_needs_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_RD) |-> ((in_depth_ff != '0) && (out_depth_ff < DEPTH_W'(CAPACITY))))
      else $error("refill started with nothing to move");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_RD) |-> (out_depth_ff != '0))
      else $error("pop read from an empty removal stack");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one beat");

   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.empty_flag) |->
         ((rsp_data.count == '0) && (rsp_data.queue_min == EMPTY_SENTINEL)))
      else $error("empty pop reported a non-empty queue");

endmodule

// ===== sv/mqts_stack_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read stack memory with registered read data.
// Generic; sized by its parameters only.
module mqts_stack_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read beat
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mqts_min_unit.sv =====
`timescale 1ns / 1ps
// Shared signed 32-bit minimum unit (one compare and a select).
// Depends on mqts_pkg for the data width.
module mqts_min_unit
   import mqts_pkg::*;
(
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output logic signed [DATA_W-1:0] min_value
);

   // Keep operand_a on a tie
   assign min_value = (operand_b < operand_a) ? operand_b : operand_a;

endmodule
